/* sv/ule_pkg.sv */
// shared types, constants and character mapping for the uuencode line encoder
package ule_pkg;

    // configuration width and reset value of the line length register
    localparam int unsigned CFG_W          = 6;
    localparam logic [5:0]  LINE_BYTES_RST = 6'd45;

    // character codes
    localparam logic [6:0] CH_ZERO = 7'd96;
    localparam logic [6:0] CH_BIAS = 7'd32;
    localparam logic [6:0] CH_NL   = 7'd10;

    // back-end sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_RD,
        S_CH,
        S_NL
    } t_state;

    // one closed line handed from the front to the back
    typedef struct packed {
        logic       vld;
        logic [5:0] cnt;
    } t_line_desc;

    // six bits to one printable character, zero maps to backtick
    function automatic logic [6:0] enc6(input logic [5:0] v);
        logic [6:0] c;
        if (v == 6'd0) begin
            c = CH_ZERO;
        end else begin
            c = {1'b0, v} + CH_BIAS;
        end
        return c;
    endfunction

endpackage

/* sv/uuencode_line_encoder.sv */
// top level of the uuencode line encoder
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata = data_byte, tlast = end_of_chunk
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata = out_char, tlast = last_of_line
//  cfg       in   i_cfg_we                     i_cfg_wdata = max_line_bytes
//
// the front takes one byte per cycle while the line queue is not full; a line of n
// bytes is then sent by the back sequencer, which pauses while the output stalls:
// it picks up the line in idle, sends the length char, and per group reads three
// bytes through the registered buffer port and sends its four characters.
// two buffer banks let the front fill the next line while the back sends one;
// s_axis_tready drops only while two closed lines are held, the one being sent
// and the next.
// reset is synchronous; the buffer needs no clearing pass.
module uuencode_line_encoder
    import ule_pkg::*;
#(
    parameter int unsigned MAX_LINE = 45
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic       m_axis_tlast
);

    localparam int unsigned IW = $clog2(MAX_LINE);
    localparam int unsigned AW = $clog2(2 * MAX_LINE);

    t_line_desc    push;
    t_line_desc    head;
    logic          q_full;
    logic          pop;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [6:0]    out_char;

    // byte intake and line closing
    ule_front #(
        .MAX_LINE (MAX_LINE),
        .IW       (IW),
        .AW       (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_eoc       (s_axis_tlast),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    // closed lines waiting for the back
    ule_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full)
    );

    // encoding and output
    ule_back #(
        .MAX_LINE (MAX_LINE),
        .IW       (IW),
        .AW       (AW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_head    (head),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_char    (out_char),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule

/* sv/ule_front.sv */
// front end: takes bytes, fills the line buffer and closes lines
module ule_front
    import ule_pkg::*;
#(
    parameter int unsigned MAX_LINE = 45,
    parameter int unsigned IW       = $clog2(MAX_LINE),
    parameter int unsigned AW       = $clog2(2 * MAX_LINE)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [5:0]    i_cfg_wdata,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data,
    input  logic          i_eoc,
    input  logic          i_q_full,
    output t_line_desc    o_push,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data
);

    logic [5:0] r_max_line;
    logic [5:0] r_cnt;
    logic [5:0] n_cnt;
    logic       r_bank;
    logic       n_bank;
    logic [5:0] lim;
    logic [5:0] cnt_inc;
    logic       room;
    logic       accept;
    logic       close;

    // clamp the configured length into 1..MAX_LINE
    always_comb begin
        if (r_max_line == 6'd0) begin
            lim = 6'd1;
        end else if (r_max_line > 6'(MAX_LINE)) begin
            lim = 6'(MAX_LINE);
        end else begin
            lim = r_max_line;
        end
    end

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign room    = r_cnt < 6'(MAX_LINE);
    assign cnt_inc = room ? r_cnt + 6'd1 : r_cnt;
    assign close   = (cnt_inc >= lim) || i_eoc;

    // buffer write, bank chosen by the side being filled
    assign o_wr_en   = accept && room;
    assign o_wr_addr = (r_bank ? AW'(MAX_LINE) : AW'(0)) + AW'(r_cnt[IW-1:0]);
    assign o_wr_data = i_data;

    // line close hands the count to the queue
    always_comb begin
        o_push.vld = accept && close;
        o_push.cnt = cnt_inc;
        n_cnt      = r_cnt;
        n_bank     = r_bank;
        if (accept) begin
            if (close) begin
                n_cnt  = 6'd0;
                n_bank = !r_bank;
            end else begin
                n_cnt = cnt_inc;
            end
        end
    end

    // control and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_line <= LINE_BYTES_RST;
            r_cnt      <= 6'd0;
            r_bank     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_line <= i_cfg_wdata;
            end
            r_cnt  <= n_cnt;
            r_bank <= n_bank;
        end
    end

endmodule

/* sv/ule_queue.sv */
// two-entry queue of closed line counts between front and back
module ule_queue
    import ule_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_line_desc i_push,
    input  logic       i_pop,
    output t_line_desc o_head,
    output logic       o_full
);

    logic [5:0] r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_pop;

    assign do_pop     = i_pop && (r_cnt != 2'd0);
    assign o_full     = r_cnt == 2'd2;
    assign o_head.vld = r_cnt != 2'd0;
    assign o_head.cnt = r_slot[r_rp];

    // payload slots
    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_slot[r_wp] <= i_push.cnt;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push.vld) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push.vld && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push.vld && do_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.vld |-> (r_cnt != 2'd2 || do_pop))
        else $error("line queue push while full");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("line queue level out of range");

endmodule

/* sv/ule_back.sv */
// back end: line buffer memory and the character sequencer
module ule_back
    import ule_pkg::*;
#(
    parameter int unsigned MAX_LINE = 45,
    parameter int unsigned IW       = $clog2(MAX_LINE),
    parameter int unsigned AW       = $clog2(2 * MAX_LINE)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  t_line_desc    i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [6:0]    o_char,
    output logic          o_last
);

    logic [7:0]    mem [2 * MAX_LINE];
    logic [7:0]    r_rd_data;
    logic          r_rd_ok;

    t_state        r_state;
    t_state        n_state;
    logic [5:0]    r_n;
    logic [5:0]    n_n;
    logic [5:0]    r_m;
    logic [5:0]    n_m;
    logic [1:0]    r_j;
    logic [1:0]    n_j;
    logic [1:0]    r_k;
    logic [1:0]    n_k;
    logic          r_bank;
    logic          n_bank;
    logic [7:0]    r_b [3];
    logic [7:0]    n_b [3];
    logic          r_ovalid;
    logic [6:0]    r_ochar;
    logic          r_olast;

    logic          slot_free;
    logic          load;
    logic [6:0]    load_char;
    logic          load_last;
    logic          rd_en;
    logic [6:0]    rd_pos;
    logic [AW-1:0] rd_addr;
    logic [5:0]    six;

    // line buffer, two banks, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign slot_free = !r_ovalid || i_ready;
    assign rd_pos    = 7'(r_m) + 7'(r_j);
    assign rd_addr   = (r_bank ? AW'(MAX_LINE) : AW'(0)) + AW'(rd_pos[IW-1:0]);

    // pick the six bits of the current group character
    always_comb begin
        case (r_k)
            2'd0:    six = r_b[0][7:2];
            2'd1:    six = {r_b[0][1:0], r_b[1][7:4]};
            2'd2:    six = {r_b[1][3:0], r_b[2][7:6]};
            default: six = r_b[2][5:0];
        endcase
    end

    // sequencer: length char, groups of four, newline
    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_m       = r_m;
        n_j       = r_j;
        n_k       = r_k;
        n_bank    = r_bank;
        n_b       = r_b;
        load      = 1'b0;
        load_char = CH_NL;
        load_last = 1'b0;
        rd_en     = 1'b0;
        o_pop     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.vld) begin
                    n_n     = i_head.cnt;
                    n_m     = 6'd0;
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                if (slot_free) begin
                    load      = 1'b1;
                    load_char = enc6(r_n);
                    n_j       = 2'd0;
                    n_state   = S_RD;
                end
            end
            S_RD: begin
                if (r_j != 2'd3) begin
                    rd_en = rd_pos < 7'(r_n);
                end
                if (r_j != 2'd0) begin
                    n_b[r_j - 2'd1] = r_rd_ok ? r_rd_data : 8'd0;
                end
                n_j = r_j + 2'd1;
                if (r_j == 2'd3) begin
                    n_k     = 2'd0;
                    n_state = S_CH;
                end
            end
            S_CH: begin
                if (slot_free) begin
                    load      = 1'b1;
                    load_char = enc6(six);
                    n_k       = r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        if (7'(r_m) + 7'd3 >= 7'(r_n)) begin
                            n_state = S_NL;
                        end else begin
                            n_m     = r_m + 6'd3;
                            n_j     = 2'd0;
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_NL: begin
                if (slot_free) begin
                    load      = 1'b1;
                    load_char = CH_NL;
                    load_last = 1'b1;
                    o_pop     = 1'b1;
                    n_bank    = !r_bank;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bank   <= 1'b0;
            r_rd_ok  <= 1'b0;
            r_ovalid <= 1'b0;
            r_j      <= 2'd0;
            r_k      <= 2'd0;
        end else begin
            r_state <= n_state;
            r_bank  <= n_bank;
            r_rd_ok <= rd_en;
            r_j     <= n_j;
            r_k     <= n_k;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // line and group payload
    always_ff @(posedge i_clk) begin
        r_n <= n_n;
        r_m <= n_m;
        r_b <= n_b;
        if (load) begin
            r_ochar <= load_char;
            r_olast <= load_last;
        end
    end

    assign o_valid = r_ovalid;
    assign o_char  = r_ochar;
    assign o_last  = r_olast;

    a_idle_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_head.vld) |=> r_state == S_IDLE)
        else $error("sequencer left idle with no line queued");

    a_group_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_CH) |-> r_m < r_n)
        else $error("group start past end of line");

    a_pop_on_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_ovalid && r_olast && r_ochar == CH_NL))
        else $error("line released without its newline");

endmodule
